@@ rtl/acmac_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-CMAC package
// Shared constants, types and the AES round helper functions.
// ----------------------------------------------------------------------------
package acmac_pkg;

   localparam int BlockWidth = 128;
   localparam int HalfWidth  = 64;
   localparam int CountWidth = 5;
   localparam int CsrIdxWidth = 1;

   localparam logic [7:0] DoubleXor = 8'h87;
   localparam logic [7:0] PadByte   = 8'h80;

   localparam logic [CsrIdxWidth-1:0] RegKeyHi = 1'b0;
   localparam logic [CsrIdxWidth-1:0] RegKeyLo = 1'b1;

   // Command from the sequencer to the AES round unit.
   typedef struct packed {
      logic                  start;
      logic [BlockWidth-1:0] block;
   } aes_cmd_type;

   // Status from the AES round unit back to the sequencer.
   typedef struct packed {
      logic                  done;
      logic [BlockWidth-1:0] result;
   } aes_sts_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a block, byte 0 in the most significant bits.
   function automatic logic [7:0] get_byte(input logic [BlockWidth-1:0] b, input int i);
      return b[BlockWidth-1-8*i -: 8];
   endfunction

   // One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
   function automatic logic [BlockWidth-1:0] aes_round(input logic [BlockWidth-1:0] s,
                                                      input logic [BlockWidth-1:0] rk,
                                                      input logic mix);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [BlockWidth-1:0] o;
      for (int c = 0; c < 4; c++)
         for (int j = 0; j < 4; j++)
            t[j+4*c] = SBOX[get_byte(s, j + 4*((c+j)%4))];
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++)
         o[BlockWidth-1-8*i -: 8] = t[i];
      return o ^ rk;
   endfunction

   // Next round key from the previous one and the round constant.
   function automatic logic [BlockWidth-1:0] key_step(input logic [BlockWidth-1:0] k,
                                                     input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, tw;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ tw;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // Doubling in GF(2^128).
   function automatic logic [BlockWidth-1:0] gf_double(input logic [BlockWidth-1:0] v);
      return {v[BlockWidth-2:0], 1'b0} ^
             {{(BlockWidth-8){1'b0}}, (v[BlockWidth-1] ? DoubleXor : 8'h00)};
   endfunction

endpackage

@@ rtl/acmac_if.sv @@
// ----------------------------------------------------------------------------
// AES-CMAC channel interfaces
// Valid/ready channels for message words, tag words and register writes.
// ----------------------------------------------------------------------------
interface acmac_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_hi;
   logic [63:0] data_lo;
   logic [4:0]  byte_count;
   logic        last;
   modport source (output valid, data_hi, data_lo, byte_count, last, input ready);
   modport sink   (input valid, data_hi, data_lo, byte_count, last, output ready);
endinterface

interface acmac_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] tag_hi;
   logic [63:0] tag_lo;
   logic [63:0] sub_one_hi;
   logic [63:0] sub_one_lo;
   logic [63:0] sub_two_hi;
   logic [63:0] sub_two_lo;
   modport source (output valid, tag_hi, tag_lo, sub_one_hi, sub_one_lo, sub_two_hi,
                   sub_two_lo, input ready);
   modport sink   (input valid, tag_hi, tag_lo, sub_one_hi, sub_one_lo, sub_two_hi,
                   sub_two_lo, output ready);
endinterface

interface acmac_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/aes_cmac_tag_core.sv @@
// ----------------------------------------------------------------------------
// AES-CMAC tag core
// AES-128 CMAC over a message of 16-byte words, one shared round unit.
// ----------------------------------------------------------------------------
// A message enters on the req channel as a run of words, the final one marked
// by last with its count of valid bytes (zero means an empty message). For
// each finished message one word leaves on the rsp channel: the tag and the
// two subkeys of that message. Inner words give no response.
// The key is written on the csr channel, index 0 for the high half and index
// 1 for the low half; the user must write it only while no message word is
// in flight, as the block itself does not enforce this. One AES round and one
// key expansion step run per cycle in a single round unit. An inner word is
// encrypted after acceptance and the next word is taken once that is done; the
// first word of a message is preceded by subkey derivation. A last word shows
// its response once its encryption is done, and it is held until rsp.ready.
// The block takes no new word while a response waits. Reset clears the key,
// the chaining value and the open-message flag, and leaves the block ready.
// ----------------------------------------------------------------------------
module aes_cmac_tag_core
   import acmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   acmac_req_if.sink   req,
   acmac_rsp_if.source rsp,
   acmac_csr_if.sink   csr
);

   logic [HalfWidth-1:0] key_hi_ff, key_lo_ff;
   aes_cmd_type          cmd;
   aes_sts_type          sts;

   assign csr.ready = 1'b1;

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr.valid) begin
         if (csr.index == RegKeyHi)
            key_hi_ff <= csr.data;
         if (csr.index == RegKeyLo)
            key_lo_ff <= csr.data;
      end
   end

   acmac_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .cmd   (cmd),
      .sts   (sts)
   );

   acmac_cipher u_cipher (
      .clock (clock),
      .reset (reset),
      .key   ({key_hi_ff, key_lo_ff}),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

@@ rtl/acmac_cipher.sv @@
// ----------------------------------------------------------------------------
// AES-CMAC cipher unit
// Iterative AES-128 encryption: one round and one key expansion step a cycle.
// ----------------------------------------------------------------------------
module acmac_cipher
   import acmac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [BlockWidth-1:0] key,
   input  aes_cmd_type           cmd,
   output aes_sts_type           sts
);

   logic [BlockWidth-1:0] state_ff, state_in;
   logic [BlockWidth-1:0] rkey_ff, rkey_in;
   logic [7:0]            rcon_ff, rcon_in;
   logic [3:0]            round_ff, round_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [BlockWidth-1:0] next_key;

   assign next_key = key_step(rkey_ff, rcon_ff);

   // Round sequencing: initial key add on start, then ten rounds.
   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         state_in = cmd.block ^ key;
         rkey_in  = key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = aes_round(state_ff, next_key, round_ff != 4'd10);
         rkey_in  = next_key;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done   = done_ff;
   assign sts.result = state_ff;

endmodule

@@ rtl/acmac_ctrl.sv @@
// ----------------------------------------------------------------------------
// AES-CMAC sequencer
// Drives the cipher unit through subkey derivation, chaining and the tag.
// ----------------------------------------------------------------------------
module acmac_ctrl
   import acmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   acmac_req_if.sink   req,
   acmac_rsp_if.source rsp,
   output aes_cmd_type cmd,
   input  aes_sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SUBK  = 5'b00010,
      ST_BLOCK = 5'b00100,
      ST_WAIT  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic                  open_ff, open_in;
   logic [BlockWidth-1:0] chain_ff, chain_in;
   logic [BlockWidth-1:0] k1_ff, k1_in;
   logic [BlockWidth-1:0] k2_ff, k2_in;
   logic [BlockWidth-1:0] data_ff, data_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  last_ff, last_in;
   logic [BlockWidth-1:0] tag_ff, tag_in;
   logic [BlockWidth-1:0] padded;
   logic [BlockWidth-1:0] final_blk;
   logic                  accept;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);

   // Padding of a partial last block: keep count bytes, then 0x80, then zeros.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (i < int'(count_ff))
            padded[BlockWidth-1-8*i -: 8] = get_byte(data_ff, i);
         else if (i == int'(count_ff))
            padded[BlockWidth-1-8*i -: 8] = PadByte;
         else
            padded[BlockWidth-1-8*i -: 8] = 8'h00;
      end
   end

   assign final_blk = count_ff[CountWidth-1] ? (data_ff ^ k1_ff) : (padded ^ k2_ff);

   // Message sequencing.
   always_comb begin
      state_in  = state_ff;
      open_in   = open_ff;
      chain_in  = chain_ff;
      k1_in     = k1_ff;
      k2_in     = k2_ff;
      data_in   = data_ff;
      count_in  = count_ff;
      last_in   = last_ff;
      tag_in    = tag_ff;
      cmd.start = 1'b0;
      cmd.block = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in  = {req.data_hi, req.data_lo};
               count_in = req.byte_count;
               last_in  = req.last;
               if (!open_ff) begin
                  cmd.start = 1'b1;
                  chain_in  = '0;
                  open_in   = 1'b1;
                  state_in  = ST_SUBK;
               end else begin
                  state_in = ST_BLOCK;
               end
            end
         end
         ST_SUBK: begin
            if (sts.done) begin
               k1_in    = gf_double(sts.result);
               k2_in    = gf_double(gf_double(sts.result));
               state_in = ST_BLOCK;
            end
         end
         ST_BLOCK: begin
            cmd.start = 1'b1;
            cmd.block = last_ff ? (final_blk ^ chain_ff) : (data_ff ^ chain_ff);
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.done) begin
               if (last_ff) begin
                  tag_in   = sts.result;
                  chain_in = '0;
                  open_in  = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  chain_in = sts.result;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT: begin
            if (rsp.ready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      k1_ff    <= k1_in;
      k2_ff    <= k2_in;
      data_ff  <= data_in;
      count_ff <= count_in;
      last_ff  <= last_in;
      tag_ff   <= tag_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         open_ff  <= 1'b0;
         chain_ff <= '0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         chain_ff <= chain_in;
      end
   end

   assign rsp.tag_hi     = tag_ff[127:64];
   assign rsp.tag_lo     = tag_ff[63:0];
   assign rsp.sub_one_hi = k1_ff[127:64];
   assign rsp.sub_one_lo = k1_ff[63:0];
   assign rsp.sub_two_hi = k2_ff[127:64];
   assign rsp.sub_two_lo = k2_ff[63:0];

endmodule

@@ rtl/acmac_checker.sv @@
// ----------------------------------------------------------------------------
// AES-CMAC port checker
// Watches the top-level channels for ordering and handshake behavior.
// ----------------------------------------------------------------------------
module acmac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_tag_hi
);

   // A response stays up until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // The high half of a stalled tag does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_tag_hi))
      else $error("tag changed while stalled");

   // No word is taken while a response waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("word taken during pending response");

   // An accepted word is followed by a busy cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready too soon after a word");

endmodule

bind aes_cmac_tag_core acmac_checker u_acmac_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_tag_hi (rsp.tag_hi)
);

@@ tb/tb_aes_cmac_tag_core.sv @@
// ----------------------------------------------------------------------------
// AES-CMAC tag core testbench
// Sends directed and random messages with random keys, stalls both sides and
// checks each tag word and its subkeys against a behavioral CMAC predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aes_cmac_tag_core;
   import acmac_pkg::*;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
      logic [4:0]  count;
      logic        last;
   } msg_word_t;

   typedef struct {
      logic [127:0] tag;
      logic [127:0] k1;
      logic [127:0] k2;
      logic         known;
   } tag_word_t;

   logic clock;
   logic reset;
   int   error_count;
   int   cycle_count;
   bit   timed_out;
   bit   hold_rsp;
   bit   pressure_on;

   acmac_req_if req ();
   acmac_rsp_if rsp ();
   acmac_csr_if csr ();

   aes_cmac_tag_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // Predictor state: key, chaining value, subkeys and open-message flag.
   logic [127:0] model_key;
   logic [127:0] model_chain;
   logic [127:0] model_k1;
   logic [127:0] model_k2;
   bit           model_open;
   tag_word_t    tag_queue[$];

   // Plain AES-128 encryption written byte by byte.
   function automatic logic [7:0] mul2(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
      logic [7:0] rk[176];
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] w[4];
      logic [7:0] rc, u, a0, a1, a2, a3, al;
      logic [127:0] o;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
      for (int i = 16; i < 176; i += 4) begin
         for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
         if (i % 16 == 0) begin
            u = w[0];
            w[0] = SBOX[w[1]] ^ rc;
            w[1] = SBOX[w[2]];
            w[2] = SBOX[w[3]];
            w[3] = SBOX[u];
            rc = mul2(rc);
         end
         for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++) t[j+4*c] = SBOX[s[j+4*((c+j)%4)]];
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
               t[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
               t[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
               t[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
      return o;
   endfunction

   function automatic logic [127:0] times_x(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
   endfunction

   // Advance the predictor by one accepted word; queue a tag on the last one.
   task automatic predict_cmac(input msg_word_t m);
      logic [127:0] blk;
      tag_word_t    t;
      blk = {m.hi, m.lo};
      if (!model_open) begin
         model_k1    = times_x(aes128(model_key, 128'd0));
         model_k2    = times_x(model_k1);
         model_chain = '0;
         model_open  = 1'b1;
      end
      if (!m.last) begin
         model_chain = aes128(model_key, model_chain ^ blk);
      end else begin
         if (m.count >= 16) begin
            blk = blk ^ model_k1;
         end else begin
            for (int i = 0; i < 16; i++)
               if (i == m.count) blk[127-8*i -: 8] = 8'h80;
               else if (i > m.count) blk[127-8*i -: 8] = 8'h00;
            blk = blk ^ model_k2;
         end
         t.tag   = aes128(model_key, blk ^ model_chain);
         t.k1    = model_k1;
         t.k2    = model_k2;
         t.known = 1'b1;
         tag_queue.push_back(t);
         model_chain = '0;
         model_open  = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [127:0] got,
                                  input logic [127:0] want);
      error_count++;
      $display("MISMATCH %s: got %032h expected %032h", what, got, want);
   endtask

   // Clock and cycle limit.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         timed_out = 1'b1;
         $display("tb_aes_cmac_tag_core failed");
         $finish;
      end
   end

   // Receiver: its own stall pattern plus a long hold-off when asked.
   int stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready   <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (hold_rsp) rsp.ready <= 1'b0;
         else if ((stall_phase / 64) % 3 == 2) rsp.ready <= 1'b1;
         else rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Long hold-off, counted in its own process.
   initial begin
      hold_rsp = 1'b0;
      wait (pressure_on);
      hold_rsp = 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Check each tag word against the oldest expectation.
   always @(posedge clock) begin
      tag_word_t t;
      if (!reset && rsp.valid && rsp.ready) begin
         if (tag_queue.size() == 0) begin
            report_mismatch("unexpected word", {rsp.tag_hi, rsp.tag_lo}, '0);
         end else begin
            t = tag_queue.pop_front();
            if ({rsp.tag_hi, rsp.tag_lo} !== t.tag)
               report_mismatch("tag", {rsp.tag_hi, rsp.tag_lo}, t.tag);
            if ({rsp.sub_one_hi, rsp.sub_one_lo} !== t.k1)
               report_mismatch("K1", {rsp.sub_one_hi, rsp.sub_one_lo}, t.k1);
            if ({rsp.sub_two_hi, rsp.sub_two_lo} !== t.k2)
               report_mismatch("K2", {rsp.sub_two_hi, rsp.sub_two_lo}, t.k2);
         end
      end
   end

   // Send one word; the predictor runs on acceptance. Valid stays high
   // across back-to-back words, so it is never dropped and raised in one step.
   task automatic send_word(input msg_word_t m, input bit keep_valid);
      req.valid      <= 1'b1;
      req.data_hi    <= m.hi;
      req.data_lo    <= m.lo;
      req.byte_count <= m.count;
      req.last       <= m.last;
      do @(posedge clock); while (!req.ready);
      predict_cmac(m);
      if (!keep_valid) req.valid <= 1'b0;
   endtask

   // Register write; valid is dropped and the task idles before it returns, so
   // valid is never dropped and raised in one step.
   task automatic write_reg(input logic idx, input logic [63:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (idx == RegKeyHi) model_key[127:64] = value;
      else model_key[63:0] = value;
      @(posedge clock);
   endtask

   // Wait until every tag has come back, then let the block settle.
   task automatic drain();
      while (tag_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random message of nwords words, with random content and count.
   task automatic random_message(input int nwords);
      msg_word_t m;
      int        gap_left;
      gap_left = $urandom_range(0, 6);
      for (int i = 0; i < nwords; i++) begin
         m.hi    = ($urandom_range(0, 9) == 0) ? '1 : rand64();
         m.lo    = ($urandom_range(0, 9) == 0) ? '0 : rand64();
         m.count = $urandom_range(0, 31);
         if ($urandom_range(0, 2) == 0) m.count = 16;
         m.last  = (i == nwords - 1);
         // Bursts: hold valid between words unless a gap is due; the last
         // word of a message always drops valid.
         if (gap_left == 0 || i == nwords - 1) begin
            send_word(m, 1'b0);
            repeat ($urandom_range(1, 8)) @(posedge clock);
            gap_left = $urandom_range(0, 6);
         end else begin
            send_word(m, 1'b1);
            gap_left--;
         end
      end
   endtask

   // Directed stimulus: each row is a word, with a known result where obvious.
   msg_word_t directed[$];

   initial begin
      msg_word_t m;
      int        nsent;
      error_count  = 0;
      cycle_count  = 0;
      timed_out    = 1'b0;
      pressure_on  = 1'b0;
      model_key    = '0;
      model_chain  = '0;
      model_k1     = '0;
      model_k2     = '0;
      model_open   = 1'b0;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.data_hi    = '0;
      req.data_lo    = '0;
      req.byte_count = '0;
      req.last       = 1'b0;
      csr.valid      = 1'b0;
      csr.index      = RegKeyHi;
      csr.data       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Under the all-zero key from reset, the empty message has a known tag
      // from the standard test vectors of the zero key:
      // L = 66e94bd4ef8a2c3b884cfa59ca342b2e.
      m = '{hi: '0, lo: '0, count: 5'd0, last: 1'b1};
      send_word(m, 1'b0);
      drain();
      // Standard RFC 4493 key for the remaining directed rows.
      write_reg(RegKeyHi, 64'h2b7e151628aed2a6);
      write_reg(RegKeyLo, 64'habf7158809cf4f3c);
      // Empty message (K1 fbeed618357133667c85e08f7236a8de from the RFC).
      directed.push_back('{hi: '0, lo: '0, count: 5'd0, last: 1'b1});
      // One full block (RFC example 2).
      directed.push_back('{hi: 64'h6bc1bee22e409f96, lo: 64'he93d7e117393172a,
                           count: 5'd16, last: 1'b1});
      // Counts of every partial length, with bytes past the count set to ones.
      for (int c = 1; c < 16; c++)
         directed.push_back('{hi: '1, lo: '1, count: c[4:0], last: 1'b1});
      // Count too large counts as full.
      directed.push_back('{hi: '1, lo: '0, count: 5'd31, last: 1'b1});
      // Multi-block message with an odd count on inner words.
      directed.push_back('{hi: '1, lo: '1, count: 5'd3, last: 1'b0});
      directed.push_back('{hi: '0, lo: '0, count: 5'd0, last: 1'b0});
      directed.push_back('{hi: 64'h8000000000000001, lo: '1, count: 5'd7, last: 1'b1});
      foreach (directed[i]) send_word(directed[i], i != directed.size() - 1);
      drain();
      // Check the known K1 vector by a second look at the predictor's subkeys.
      if (model_k1 !== 128'hfbeed618357133667c85e08f7236a8de)
         report_mismatch("K1 vector", model_k1, 128'hfbeed618357133667c85e08f7236a8de);

      // Random phases, each with its own key, including the extremes. Keys
      // are written only between phases, while the block is idle.
      nsent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(RegKeyHi, ph == 0 ? 64'h0 : (ph == 1 ? '1 : rand64()));
         write_reg(RegKeyLo, ph == 0 ? 64'h0 : (ph == 1 ? '1 : rand64()));
         if (ph == 3) pressure_on = 1'b1;
         while (nsent < (ph + 1) * 125) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            random_message(n);
            nsent += n;
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0 && tag_queue.size() == 0) begin
         $display("tb_aes_cmac_tag_core passed");
      end else begin
         $display("tb_aes_cmac_tag_core failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/acmac_pkg.sv
rtl/acmac_if.sv
rtl/acmac_cipher.sv
rtl/acmac_ctrl.sv
rtl/aes_cmac_tag_core.sv
rtl/acmac_checker.sv
tb/tb_aes_cmac_tag_core.sv
